[rtl/core/vct_pkg.sv]
// Package for the vector clock table: shared types, widths and defaults.
// Used by vct_seq and vector_clock_table; no dependencies.
package vct_pkg;

   localparam int DEF_MAX_NODES   = 8;
   localparam int DEF_COUNT_WIDTH = 32;

   // Node ids on the ports are 3 bits; column counts follow the 4-bit register.
   localparam int NODE_W      = 3;
   localparam int COL_W       = 4;
   localparam int VALUE_W     = 32;
   localparam int NODES_RESET = 8;

   localparam logic OP_LOCAL = 1'b0;
   localparam logic OP_SEND  = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REJECT,
      ST_SWEEP,
      ST_FIXUP
   } state_type;

   typedef enum logic [1:0] {
      WS_ZERO,
      WS_UPDATE,
      WS_FIX
   } wsel_type;

   typedef struct packed {
      logic              pend;
      logic              reject;
      logic              is_send;
      logic              last;
      logic [NODE_W-1:0] src;
      logic [NODE_W-1:0] dst;
      logic [COL_W-1:0]  col;
      logic              wr_en;
      wsel_type          wr_sel;
   } seq_ctl_type;

endpackage

[rtl/core/vector_clock_table.sv]
// Vector clock table: one clock row per node in a single RAM, updated per event.
// Depends on vct_pkg, vct_ram, vct_update and vct_seq.
//
// Use: drive req_operation, req_node and req_receiver_node with start high;
// the request is taken at the clock edge where start is high and busy is low.
// A local event bumps the node's own counter; a send bumps the sender's own
// counter, merges the sender row into the receiver row by maximum and bumps
// the receiver's own counter. The updated row (n = min(nodes_in_use,
// MAX_NODES) entries, index 0 first) comes out on the rsp_ ports, one entry
// per cycle on consecutive cycles, each marked by rsp_valid for one cycle;
// rsp_last flags the final entry. The first entry appears after the RAM's
// registered read and the result register. A request naming a node (for a
// send, also a receiver) not below n gives one result with rsp_rejected set.
// Throughput: one row sweep through the RAM's two read ports, one column per
// cycle, after a registered read; a send to another node adds one write for
// the sender's own counter, and a rejected request has no sweep. A new
// request is taken only when the previous one is done and busy is low.
// Reset: the table is cleared by a pass over all MAX_NODES * MAX_NODES cells
// with busy high; nodes_in_use returns to 8. csr_wr_en writes nodes_in_use
// at any time, but only while idle is it meaningful. The receiver cannot stall.
module vector_clock_table #(
   parameter int MAX_NODES   = vct_pkg::DEF_MAX_NODES,
   parameter int COUNT_WIDTH = vct_pkg::DEF_COUNT_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_operation,
   input  logic [vct_pkg::NODE_W-1:0]  req_node,
   input  logic [vct_pkg::NODE_W-1:0]  req_receiver_node,
   output logic                        rsp_valid,
   output logic [vct_pkg::NODE_W-1:0]  rsp_row_node,
   output logic [vct_pkg::NODE_W-1:0]  rsp_entry_index,
   output logic [vct_pkg::VALUE_W-1:0] rsp_entry_value,
   output logic                        rsp_rejected,
   output logic                        rsp_last,
   input  logic                        csr_wr_en,
   input  logic [vct_pkg::COL_W-1:0]   csr_wr_data
);
   import vct_pkg::*;

   localparam int DEPTH = MAX_NODES * MAX_NODES;
   localparam int AW    = $clog2(DEPTH);
   localparam int NCAP  = (MAX_NODES < 15) ? MAX_NODES : 15;

   logic [COL_W-1:0]       nodes_in_use_ff;
   logic [COL_W-1:0]       n_active;
   seq_ctl_type            ctl;
   logic [AW-1:0]          rd_addr_a;
   logic [AW-1:0]          rd_addr_b;
   logic [AW-1:0]          wr_addr;
   logic [COUNT_WIDTH-1:0] wr_data;
   logic [COUNT_WIDTH-1:0] src_val;
   logic [COUNT_WIDTH-1:0] dst_val;
   logic [COUNT_WIDTH-1:0] src_bumped;
   logic [COUNT_WIDTH-1:0] new_val;
   logic                   src_hit;
   logic                   dst_hit;
   logic [COUNT_WIDTH-1:0] fix_val_ff, fix_val_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0]      rsp_row_node_ff, rsp_row_node_in;
   logic [NODE_W-1:0]      rsp_entry_index_ff, rsp_entry_index_in;
   logic [VALUE_W-1:0]     rsp_entry_value_ff, rsp_entry_value_in;
   logic                   rsp_rejected_ff, rsp_rejected_in;
   logic                   rsp_last_ff, rsp_last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         nodes_in_use_ff <= COL_W'(NODES_RESET);
      end else if (csr_wr_en) begin
         nodes_in_use_ff <= csr_wr_data;
      end
   end

   assign n_active = (32'(nodes_in_use_ff) > MAX_NODES) ? COL_W'(NCAP) : nodes_in_use_ff;

   vct_seq #(
      .MAX_NODES (MAX_NODES)
   ) u_seq (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_node          (req_node),
      .req_receiver_node (req_receiver_node),
      .n_active          (n_active),
      .rd_addr_a         (rd_addr_a),
      .rd_addr_b         (rd_addr_b),
      .wr_addr           (wr_addr),
      .ctl               (ctl)
   );

   vct_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (DEPTH)
   ) u_table (
      .clock     (clock),
      .wr_en     (ctl.wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (src_val),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (dst_val)
   );

   assign src_hit = (ctl.col == {1'b0, ctl.src});
   assign dst_hit = (ctl.col == {1'b0, ctl.dst});

   vct_update #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_update (
      .src_val    (src_val),
      .dst_val    (dst_val),
      .src_hit    (src_hit),
      .dst_hit    (dst_hit),
      .is_send    (ctl.is_send),
      .src_bumped (src_bumped),
      .new_val    (new_val)
   );

   always_comb begin
      case (ctl.wr_sel)
         WS_ZERO:   wr_data = '0;
         WS_UPDATE: wr_data = new_val;
         WS_FIX:    wr_data = fix_val_ff;
         default:   wr_data = '0;
      endcase
   end

   // hold the sender's bumped own counter until the fix-up write
   assign fix_val_in = (ctl.pend && src_hit) ? src_bumped : fix_val_ff;

   always_comb begin
      rsp_valid_in       = ctl.pend || ctl.reject;
      rsp_row_node_in    = ctl.dst;
      rsp_entry_index_in = NODE_W'(ctl.col);
      rsp_entry_value_in = VALUE_W'(new_val);
      rsp_rejected_in    = 1'b0;
      rsp_last_in        = ctl.last;
      if (ctl.reject) begin
         rsp_row_node_in    = ctl.src;
         rsp_entry_index_in = '0;
         rsp_entry_value_in = '0;
         rsp_rejected_in    = 1'b1;
         rsp_last_in        = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fix_val_ff         <= fix_val_in;
      rsp_row_node_ff    <= rsp_row_node_in;
      rsp_entry_index_ff <= rsp_entry_index_in;
      rsp_entry_value_ff <= rsp_entry_value_in;
      rsp_rejected_ff    <= rsp_rejected_in;
      rsp_last_ff        <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_row_node    = rsp_row_node_ff;
   assign rsp_entry_index = rsp_entry_index_ff;
   assign rsp_entry_value = rsp_entry_value_ff;
   assign rsp_rejected    = rsp_rejected_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef SYNTHESIS
   a_write_only_busy: assert property (@(posedge clock) disable iff (reset)
      ctl.wr_en |-> busy)
      else $error("table written while idle");

   a_no_result_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid)
      else $error("result strobe right after a new request");

   a_reject_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_rejected) |-> (rsp_last && (rsp_entry_value == '0)))
      else $error("rejected result not a single empty entry");

   a_busy_during_sweep: assert property (@(posedge clock) disable iff (reset)
      ctl.pend |-> (busy && !ctl.reject))
      else $error("column pending outside a sweep");
`endif

endmodule

[rtl/core/vct_ram.sv]
// Generic synchronous RAM: one write port, two read ports, registered reads.
// No dependencies.
module vct_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem[rd_addr_a];
      rd_data_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

[rtl/core/vct_update.sv]
// Column update: sender self-increment, element-wise maximum, receiver increment.
// Pure logic on one column of the sender and receiver rows; no dependencies.
module vct_update #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic [COUNT_WIDTH-1:0] src_val,
   input  logic [COUNT_WIDTH-1:0] dst_val,
   input  logic                   src_hit,
   input  logic                   dst_hit,
   input  logic                   is_send,
   output logic [COUNT_WIDTH-1:0] src_bumped,
   output logic [COUNT_WIDTH-1:0] new_val
);

   logic [COUNT_WIDTH-1:0] merged;

   always_comb begin
      src_bumped = src_val;
      if (src_hit && (src_val != {COUNT_WIDTH{1'b1}})) begin
         src_bumped = src_val + COUNT_WIDTH'(1);
      end
      merged = (src_bumped > dst_val) ? src_bumped : dst_val;
      new_val = merged;
      // second increment only on the receiver's own entry of a send
      if (is_send && dst_hit && (merged != {COUNT_WIDTH{1'b1}})) begin
         new_val = merged + COUNT_WIDTH'(1);
      end
   end

endmodule

[rtl/core/vct_seq.sv]
// Sequencer: clearing pass, event capture and rejection, column sweep and sender fix-up write.
// Depends on vct_pkg; drives the table RAM addresses and the result control.
module vct_seq #(
   parameter int MAX_NODES = vct_pkg::DEF_MAX_NODES
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic                                     req_operation,
   input  logic [vct_pkg::NODE_W-1:0]               req_node,
   input  logic [vct_pkg::NODE_W-1:0]               req_receiver_node,
   input  logic [vct_pkg::COL_W-1:0]                n_active,
   output logic [$clog2(MAX_NODES*MAX_NODES)-1:0]   rd_addr_a,
   output logic [$clog2(MAX_NODES*MAX_NODES)-1:0]   rd_addr_b,
   output logic [$clog2(MAX_NODES*MAX_NODES)-1:0]   wr_addr,
   output vct_pkg::seq_ctl_type                     ctl
);
   import vct_pkg::*;

   localparam int DEPTH = MAX_NODES * MAX_NODES;
   localparam int AW    = $clog2(DEPTH);

   state_type         state_ff, state_in;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;
   logic              op_ff, op_in;
   logic [NODE_W-1:0] src_ff, src_in;
   logic [NODE_W-1:0] dst_ff, dst_in;
   logic [COL_W-1:0]  issue_ff, issue_in;
   logic              pend_ff, pend_in;
   logic [COL_W-1:0]  pend_col_ff, pend_col_in;
   logic              accept;
   logic              reject_req;
   logic              pend_last;

   function automatic logic [AW-1:0] cell_addr(input logic [NODE_W-1:0] row,
                                               input logic [COL_W-1:0]  col);
      cell_addr = AW'(AW'(row) * AW'(MAX_NODES)) + AW'(col);
   endfunction

   assign accept     = start && (state_ff == ST_IDLE);
   assign reject_req = ({1'b0, req_node} >= n_active) ||
                       ((req_operation == OP_SEND) && ({1'b0, req_receiver_node} >= n_active));
   assign pend_last  = pend_ff && ((pend_col_ff + COL_W'(1)) == n_active);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = reject_req ? ST_REJECT : ST_SWEEP;
            end
         end
         ST_REJECT: state_in = ST_IDLE;
         ST_SWEEP: begin
            if (pend_last) begin
               state_in = ((op_ff == OP_SEND) && (src_ff != dst_ff)) ? ST_FIXUP : ST_IDLE;
            end
         end
         ST_FIXUP: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // sweep counters and captured request
   always_comb begin
      clr_addr_in = clr_addr_ff;
      op_in       = op_ff;
      src_in      = src_ff;
      dst_in      = dst_ff;
      issue_in    = issue_ff;
      pend_in     = 1'b0;
      pend_col_in = pend_col_ff;
      if (state_ff == ST_CLEAR) begin
         clr_addr_in = clr_addr_ff + AW'(1);
      end
      if (accept) begin
         op_in    = req_operation;
         src_in   = req_node;
         dst_in   = (req_operation == OP_SEND) ? req_receiver_node : req_node;
         issue_in = '0;
      end
      // issue one column read per cycle; data returns next cycle
      if ((state_ff == ST_SWEEP) && (issue_ff < n_active)) begin
         pend_in     = 1'b1;
         pend_col_in = issue_ff;
         issue_in    = issue_ff + COL_W'(1);
      end
   end

   // outputs
   always_comb begin
      busy        = (state_ff != ST_IDLE);
      rd_addr_a   = cell_addr(src_ff, issue_ff);
      rd_addr_b   = cell_addr(dst_ff, issue_ff);
      wr_addr     = cell_addr(dst_ff, pend_col_ff);
      ctl.pend    = pend_ff && (state_ff == ST_SWEEP);
      ctl.reject  = (state_ff == ST_REJECT);
      ctl.is_send = (op_ff == OP_SEND);
      ctl.last    = pend_last;
      ctl.src     = src_ff;
      ctl.dst     = dst_ff;
      ctl.col     = pend_col_ff;
      ctl.wr_en   = 1'b0;
      ctl.wr_sel  = WS_UPDATE;
      case (state_ff)
         ST_CLEAR: begin
            ctl.wr_en  = 1'b1;
            ctl.wr_sel = WS_ZERO;
            wr_addr    = clr_addr_ff;
         end
         ST_SWEEP: begin
            ctl.wr_en  = pend_ff;
            ctl.wr_sel = WS_UPDATE;
         end
         ST_FIXUP: begin
            ctl.wr_en  = 1'b1;
            ctl.wr_sel = WS_FIX;
            wr_addr    = cell_addr(src_ff, COL_W'(src_ff));
         end
         default: begin
            ctl.wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         pend_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         pend_ff     <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      issue_ff    <= issue_in;
      pend_col_ff <= pend_col_in;
   end

endmodule

[sim/testbench.sv]
// Testbench for vector_clock_table: directed and random requests, with a scoreboard of row entries.
// Depends on vct_pkg and the vector_clock_table RTL; needs no other file.
`timescale 1ns / 100ps

module testbench;

   typedef struct {
      logic                      op;
      logic [vct_pkg::NODE_W-1:0] node;
      logic [vct_pkg::NODE_W-1:0] receiver;
   } clock_event_type;

   typedef struct {
      logic [vct_pkg::NODE_W-1:0]  row_node;
      logic [vct_pkg::NODE_W-1:0]  entry_index;
      logic [vct_pkg::VALUE_W-1:0] entry_value;
      logic                        rejected;
      logic                        last;
   } row_entry_type;

   localparam int MAX_NODES = vct_pkg::DEF_MAX_NODES;
   localparam int NODE_W    = vct_pkg::NODE_W;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_operation = vct_pkg::OP_LOCAL;
   logic [vct_pkg::NODE_W-1:0] req_node = '0;
   logic [vct_pkg::NODE_W-1:0] req_receiver_node = '0;
   logic rsp_valid;
   logic [vct_pkg::NODE_W-1:0] rsp_row_node;
   logic [vct_pkg::NODE_W-1:0] rsp_entry_index;
   logic [vct_pkg::VALUE_W-1:0] rsp_entry_value;
   logic rsp_rejected;
   logic rsp_last;
   logic csr_wr_en = 1'b0;
   logic [vct_pkg::COL_W-1:0] csr_wr_data = '0;

   vector_clock_table uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_node          (req_node),
      .req_receiver_node (req_receiver_node),
      .rsp_valid         (rsp_valid),
      .rsp_row_node      (rsp_row_node),
      .rsp_entry_index   (rsp_entry_index),
      .rsp_entry_value   (rsp_entry_value),
      .rsp_rejected      (rsp_rejected),
      .rsp_last          (rsp_last),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always #1 clock = ~clock;

   // Shadow copy of the clock table and the node count register.
   logic [vct_pkg::VALUE_W-1:0] vc_rows [MAX_NODES][MAX_NODES];
   logic [vct_pkg::COL_W-1:0]   nodes_in_use = vct_pkg::NODES_RESET[vct_pkg::COL_W-1:0];

   clock_event_type event_queue[$];
   row_entry_type   expected_entries[$];
   int              mismatch_count = 0;
   int              burst_left = 1;
   int              gap_left = 0;

   function automatic int active_nodes();
      return (nodes_in_use > MAX_NODES) ? MAX_NODES : int'(nodes_in_use);
   endfunction

   function automatic logic [vct_pkg::VALUE_W-1:0] sat_inc(logic [vct_pkg::VALUE_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   // Update the shadow table for one request and queue the row entries it yields.
   function automatic void apply_event(clock_event_type ev);
      int n;
      logic [vct_pkg::NODE_W-1:0] row;
      row_entry_type e;
      n = active_nodes();
      if (ev.node >= n || (ev.op == vct_pkg::OP_SEND && ev.receiver >= n)) begin
         e.row_node    = ev.node;
         e.entry_index = '0;
         e.entry_value = '0;
         e.rejected    = 1'b1;
         e.last        = 1'b1;
         expected_entries.push_back(e);
         return;
      end
      vc_rows[ev.node][ev.node] = sat_inc(vc_rows[ev.node][ev.node]);
      if (ev.op == vct_pkg::OP_SEND) begin
         for (int i = 0; i < n; i++)
            if (vc_rows[ev.node][i] > vc_rows[ev.receiver][i])
               vc_rows[ev.receiver][i] = vc_rows[ev.node][i];
         vc_rows[ev.receiver][ev.receiver] = sat_inc(vc_rows[ev.receiver][ev.receiver]);
         row = ev.receiver;
      end else begin
         row = ev.node;
      end
      for (int i = 0; i < n; i++) begin
         e.row_node    = row;
         e.entry_index = i[vct_pkg::NODE_W-1:0];
         e.entry_value = vc_rows[row][i];
         e.rejected    = 1'b0;
         e.last        = (i == n - 1);
         expected_entries.push_back(e);
      end
   endfunction

   // Request driver: bursts of back-to-back requests separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            apply_event(event_queue.pop_front());
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 20);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
            end
         end
         if (start && busy) begin
            // hold the request until it is taken
         end else if (gap_left > 0 || event_queue.size() == 0) begin
            if (gap_left > 0)
               gap_left--;
            start             <= 1'b0;
            req_operation     <= 1'($urandom_range(0, 1));
            req_node          <= NODE_W'($urandom_range(0, 7));
            req_receiver_node <= NODE_W'($urandom_range(0, 7));
         end else begin
            start             <= 1'b1;
            req_operation     <= event_queue[0].op;
            req_node          <= event_queue[0].node;
            req_receiver_node <= event_queue[0].receiver;
         end
      end
   end

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   // Result monitor: every strobed entry must match the oldest expectation.
   always @(posedge clock) begin
      row_entry_type e;
      if (!reset && rsp_valid) begin
         if (expected_entries.size() == 0) begin
            $display("%0t: unexpected result, row %0d entry %0d value %0h", $realtime,
                     rsp_row_node, rsp_entry_index, rsp_entry_value);
            mismatch_count++;
         end else begin
            e = expected_entries.pop_front();
            check_field("row_node", 32'(e.row_node), 32'(rsp_row_node));
            check_field("entry_index", 32'(e.entry_index), 32'(rsp_entry_index));
            check_field("entry_value", e.entry_value, rsp_entry_value);
            check_field("rejected", 32'(e.rejected), 32'(rsp_rejected));
            check_field("last", 32'(e.last), 32'(rsp_last));
         end
      end
   end

   task automatic add_event(logic op, int node, int receiver);
      clock_event_type ev;
      ev.op       = op;
      ev.node     = node[vct_pkg::NODE_W-1:0];
      ev.receiver = receiver[vct_pkg::NODE_W-1:0];
      event_queue.push_back(ev);
   endtask

   // Mostly in-range nodes so that updates dominate; the rest hit any index.
   task automatic add_random(int count);
      int n;
      n = active_nodes();
      for (int k = 0; k < count; k++)
         if (n > 0 && $urandom_range(0, 9) < 8)
            add_event(1'($urandom_range(0, 1)), int'($urandom_range(0, n - 1)),
                      int'($urandom_range(0, n - 1)));
         else
            add_event(1'($urandom_range(0, 1)), int'($urandom_range(0, 7)),
                      int'($urandom_range(0, 7)));
   endtask

   task automatic drain();
      while (event_queue.size() != 0 || expected_entries.size() != 0)
         @(posedge clock);
      while (busy)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_nodes(int value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value[vct_pkg::COL_W-1:0];
      nodes_in_use = value[vct_pkg::COL_W-1:0];
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      for (int r = 0; r < MAX_NODES; r++)
         for (int c = 0; c < MAX_NODES; c++)
            vc_rows[r][c] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset count of eight: corner nodes, sends both ways, sends to self.
      add_event(vct_pkg::OP_LOCAL, 0, 7);
      add_event(vct_pkg::OP_LOCAL, 7, 0);
      add_event(vct_pkg::OP_SEND, 0, 7);
      add_event(vct_pkg::OP_SEND, 7, 0);
      add_event(vct_pkg::OP_SEND, 3, 3);
      add_event(vct_pkg::OP_SEND, 7, 7);
      add_event(vct_pkg::OP_LOCAL, 5, 5);
      add_event(vct_pkg::OP_SEND, 2, 5);
      add_event(vct_pkg::OP_SEND, 5, 2);
      add_event(vct_pkg::OP_SEND, 6, 1);
      add_event(vct_pkg::OP_SEND, 1, 6);
      add_event(vct_pkg::OP_LOCAL, 4, 7);
      add_random(60);
      drain();

      // Zero nodes: everything is rejected.
      write_nodes(0);
      add_event(vct_pkg::OP_LOCAL, 0, 0);
      add_event(vct_pkg::OP_SEND, 0, 0);
      add_random(10);
      drain();

      // One node: only node 0 works, and a send only to itself.
      write_nodes(1);
      add_event(vct_pkg::OP_LOCAL, 0, 3);
      add_event(vct_pkg::OP_SEND, 0, 0);
      add_event(vct_pkg::OP_SEND, 0, 1);
      add_event(vct_pkg::OP_LOCAL, 1, 0);
      add_event(vct_pkg::OP_SEND, 1, 0);
      add_random(20);
      drain();

      write_nodes(2);
      add_event(vct_pkg::OP_SEND, 1, 0);
      add_event(vct_pkg::OP_SEND, 0, 2);
      add_random(50);
      drain();

      // Counts above the table size act as a full table.
      write_nodes(15);
      add_event(vct_pkg::OP_SEND, 7, 6);
      add_event(vct_pkg::OP_LOCAL, 7, 0);
      add_random(50);
      drain();

      write_nodes(5);
      add_random(50);
      drain();
      write_nodes(9);
      add_random(30);
      drain();
      write_nodes(3);
      add_random(40);
      drain();
      write_nodes(8);
      add_random(50);
      drain();

      repeat (12) @(posedge clock);
      if (mismatch_count == 0 && expected_entries.size() == 0)
         $display("[vector_clock_table] OK");
      else
         $display("[vector_clock_table] ERROR");
      $finish;
   end

   initial begin
      #400000;
      $display("[vector_clock_table] ERROR");
      $finish;
   end

endmodule

[files.f]
rtl/core/vct_pkg.sv
rtl/core/vct_ram.sv
rtl/core/vct_update.sv
rtl/core/vct_seq.sv
rtl/core/vector_clock_table.sv
sim/testbench.sv
